### sv/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 engine.
`default_nettype none

package sha256_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [7:0][31:0] hash_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_EMIT
    } state_t;

    // Kind of block fed to the compression: plain data, or one of the padding forms.
    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD_LEN,
        BLK_PAD_ONLY,
        BLK_LEN_ONLY
    } blk_t;

    localparam logic [1:0] MODE_ABSORB        = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] MODE_FINISH        = 2'd2;
    localparam logic [1:0] MODE_DROP          = 2'd3;   // undefined, beat has no effect

    localparam logic [6:0] LAST_STEP     = 7'd66;
    localparam logic [5:0] LEN_FIT_LIMIT = 6'd55;
    localparam logic [7:0] PAD_BYTE      = 8'h80;

    typedef struct packed {
        logic       init;
        logic       sched_en;
        logic       from_mem;
        logic       round_en;
        logic [5:0] k_idx;
    } cmp_ctl_t;

    localparam hash_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t bsig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t ssig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t ch_fn(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t maj_fn(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    // Schedule word j of a block: buffer bytes below the fill point, then 0x80,
    // zero fill and the bit length, as the block kind asks.
    function automatic word_t pad_word(input blk_t kind, input logic [3:0] j,
                                       input word_t d, input logic [5:0] f,
                                       input logic [63:0] bits);
        word_t      r;
        logic [5:0] p;
        r = '0;
        p = '0;
        if (kind == BLK_DATA) begin
            r = d;
        end
        else begin
            for (int l = 0; l < 4; l++) begin
                p = {j, 2'(l)};
                if (kind == BLK_LEN_ONLY)
                    r[31 - 8 * l -: 8] = '0;
                else if (p < f)
                    r[31 - 8 * l -: 8] = d[31 - 8 * l -: 8];
                else if (p == f)
                    r[31 - 8 * l -: 8] = PAD_BYTE;
                else
                    r[31 - 8 * l -: 8] = '0;
            end
            if (kind != BLK_PAD_ONLY && j == 4'd14)
                r = bits[63:32];
            if (kind != BLK_PAD_ONLY && j == 4'd15)
                r = bits[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/sha256_hash_engine_unit.sv
// SHA-256 engine top level: byte intake, block buffer memory, control and digest output.
//
// Usage:
//   Input beats on s_axis carry a mode and a message byte. Mode 0 absorbs
//   the byte, mode 1 absorbs it and finishes the message, mode 2 finishes
//   without a byte, mode 3 is dropped with no effect.
//   Each finish produces one output beat on m_axis: the 256-bit digest,
//   digest bytes 0..7 (big-endian) in tdata[63:0], bytes 24..31 in [255:192].
// Flow:
//   Absorbed bytes are taken back to back while idle. The 64th byte of a
//   block starts a compression (16-word buffer read, then one round per cycle
//   through a single round unit); s_axis_tready is low meanwhile.
//   A finish runs one padding block, or two if more than 55 bytes are
//   pending, after a data block if its own byte filled a block, and then
//   moves the digest into the output register.
// Reset clears the hash words to the initial values and the counters; the
//   block buffer memory needs no clearing, since padding masks unwritten bytes.
// Stall: the digest waits in the output register while m_axis_tready is low;
//   bytes of the next message are still taken, a further finish waits.
`default_nettype none

module sha256_hash_engine_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [1:0] mode, [9:2] data_byte, [15:10] zero
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [255:0]      m_axis_tdata    // digest_part0, part1, part2, part3
);

    sha256_pkg::state_t state_reg, state_next;
    sha256_pkg::blk_t   blk_reg, blk_next;
    logic [6:0]         step_reg, step_next;
    logic               fin_reg, fin_next;
    logic [5:0]         fill_reg, fill_next;
    logic [60:0]        count_reg, count_next;
    sha256_pkg::hash_t  hash_reg, hash_next;
    logic               out_valid_reg, out_valid_next;
    logic [255:0]       out_data_reg;

    logic [31:0]        buf_mem [16];
    logic [31:0]        rd_data_reg;

    logic [1:0]         in_mode;
    logic [7:0]         in_byte;
    logic               s_acc;
    logic               absorb;
    logic               finish;
    logic [5:0]         fill_after;
    logic               out_load;
    logic [6:0]         step_m1;
    sha256_pkg::cmp_ctl_t ctl;
    sha256_pkg::word_t  w_mem;
    sha256_pkg::hash_t  vars;

    assign in_mode    = s_axis_tdata[1:0];
    assign in_byte    = s_axis_tdata[9:2];
    assign s_axis_tready = (state_reg == sha256_pkg::S_IDLE);
    assign s_acc      = s_axis_tvalid && s_axis_tready;
    assign absorb     = (in_mode == sha256_pkg::MODE_ABSORB)
                     || (in_mode == sha256_pkg::MODE_ABSORB_FINISH);
    assign finish     = (in_mode == sha256_pkg::MODE_ABSORB_FINISH)
                     || (in_mode == sha256_pkg::MODE_FINISH);
    assign fill_after = absorb ? fill_reg + 6'd1 : fill_reg;

    // Block buffer: 16 big-endian words, byte-lane writes, registered read.
    always_ff @(posedge clk)
    begin
        if (s_acc && absorb)
            buf_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= in_byte;
        rd_data_reg <= buf_mem[step_reg[3:0]];
    end

    // Step 0..15 issue reads, 1..64 build schedule words, 2..65 run rounds,
    // 66 folds the working variables into the hash.
    assign step_m1      = step_reg - 7'd1;
    assign ctl.init     = (state_reg == sha256_pkg::S_COMP) && (step_reg == 7'd0);
    assign ctl.sched_en = (state_reg == sha256_pkg::S_COMP) && (step_reg >= 7'd1)
                       && (step_reg <= 7'd64);
    assign ctl.from_mem = (step_reg <= 7'd16);
    assign ctl.round_en = (state_reg == sha256_pkg::S_COMP) && (step_reg >= 7'd2)
                       && (step_reg <= 7'd65);
    assign ctl.k_idx    = step_m1[5:0];

    assign w_mem = sha256_pkg::pad_word(blk_reg, step_m1[3:0], rd_data_reg, fill_reg,
                                        {count_reg, 3'b000});

    sha256_compress u_compress (
        .clk     (clk),
        .ctl     (ctl),
        .w_mem   (w_mem),
        .hash_in (hash_reg),
        .vars    (vars)
    );

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        step_next  = step_reg;
        fin_next   = fin_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        hash_next  = hash_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            sha256_pkg::S_IDLE:
            begin
                if (s_acc)
                begin
                    if (absorb)
                    begin
                        fill_next  = fill_after;
                        count_next = count_reg + 61'd1;
                    end
                    step_next = '0;
                    priority if (absorb && fill_reg == 6'd63)
                    begin
                        state_next = sha256_pkg::S_COMP;
                        blk_next   = sha256_pkg::BLK_DATA;
                        fin_next   = finish;
                    end
                    else if (finish)
                    begin
                        state_next = sha256_pkg::S_COMP;
                        blk_next   = (fill_after <= sha256_pkg::LEN_FIT_LIMIT)
                                   ? sha256_pkg::BLK_PAD_LEN : sha256_pkg::BLK_PAD_ONLY;
                        fin_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = sha256_pkg::S_IDLE;
                    end
                end
            end
            sha256_pkg::S_COMP:
            begin
                step_next = step_reg + 7'd1;
                if (step_reg == sha256_pkg::LAST_STEP)
                begin
                    step_next = '0;
                    for (int i = 0; i < 8; i++)
                        hash_next[i] = hash_reg[i] + vars[i];
                    unique case (blk_reg)
                        sha256_pkg::BLK_DATA:
                        begin
                            // a finish whose byte closed the block pads from byte 0
                            if (fin_reg)
                                blk_next = sha256_pkg::BLK_PAD_LEN;
                            else
                                state_next = sha256_pkg::S_IDLE;
                        end
                        sha256_pkg::BLK_PAD_ONLY:
                            blk_next = sha256_pkg::BLK_LEN_ONLY;
                        sha256_pkg::BLK_PAD_LEN,
                        sha256_pkg::BLK_LEN_ONLY:
                            state_next = sha256_pkg::S_EMIT;
                    endcase
                end
            end
            sha256_pkg::S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    hash_next  = sha256_pkg::HASH_IV;
                    fill_next  = '0;
                    count_next = '0;
                    fin_next   = 1'b0;
                    state_next = sha256_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sha256_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::S_IDLE;
            blk_reg       <= sha256_pkg::BLK_DATA;
            step_reg      <= '0;
            fin_reg       <= 1'b0;
            fill_reg      <= '0;
            count_reg     <= '0;
            hash_reg      <= sha256_pkg::HASH_IV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blk_reg       <= blk_next;
            step_reg      <= step_next;
            fin_reg       <= fin_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // digest words: part0 = {H0, H1} in the lowest bits
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {hash_reg[6], hash_reg[7],
                             hash_reg[4], hash_reg[5], hash_reg[2], hash_reg[3],
                             hash_reg[0], hash_reg[1]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // 64th byte of a block must start a compression
    a_full_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && in_mode == sha256_pkg::MODE_ABSORB && fill_reg == 6'd63
        |=> state_reg == sha256_pkg::S_COMP && step_reg == 7'd0)
        else $error("full block did not start compression");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha256_pkg::S_COMP |-> step_reg <= sha256_pkg::LAST_STEP)
        else $error("compression step out of range");

    a_emit_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha256_pkg::S_EMIT && (!out_valid_reg || m_axis_tready)
        |=> hash_reg == sha256_pkg::HASH_IV && fill_reg == 6'd0 && count_reg == 61'd0
            && m_axis_tvalid)
        else $error("engine not reinitialised after digest");

    a_undefined_mode: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && in_mode == sha256_pkg::MODE_DROP
        |=> $stable(count_reg) && $stable(fill_reg) && state_reg == sha256_pkg::S_IDLE)
        else $error("undefined mode changed state");

endmodule

`default_nettype wire

### sv/sha256_compress.sv
// Message schedule and round datapath: one schedule word and one round per cycle while enabled.
`default_nettype none

module sha256_compress (
    input  wire logic                 clk,
    input  wire sha256_pkg::cmp_ctl_t ctl,
    input  wire sha256_pkg::word_t    w_mem,
    input  wire sha256_pkg::hash_t    hash_in,
    output sha256_pkg::hash_t         vars
);

    sha256_pkg::word_t w_sr_reg [16];
    sha256_pkg::word_t wk_reg;
    sha256_pkg::hash_t v_reg;

    sha256_pkg::word_t w_new;
    sha256_pkg::word_t t1;
    sha256_pkg::word_t t2;

    always_comb
    begin
        if (ctl.from_mem)
            w_new = w_mem;
        else
            w_new = w_sr_reg[0] + sha256_pkg::ssig0(w_sr_reg[1]) + w_sr_reg[9]
                  + sha256_pkg::ssig1(w_sr_reg[14]);
        t1 = v_reg[7] + sha256_pkg::bsig1(v_reg[4])
           + sha256_pkg::ch_fn(v_reg[4], v_reg[5], v_reg[6]) + wk_reg;
        t2 = sha256_pkg::bsig0(v_reg[0]) + sha256_pkg::maj_fn(v_reg[0], v_reg[1], v_reg[2]);
    end

    // schedule window: [0] is w[i-16], [15] the newest word
    always_ff @(posedge clk)
    begin
        if (ctl.sched_en)
        begin
            for (int i = 0; i < 15; i++)
                w_sr_reg[i] <= w_sr_reg[i + 1];
            w_sr_reg[15] <= w_new;
            wk_reg       <= w_new + sha256_pkg::ROUND_K[ctl.k_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
            v_reg <= hash_in;
        else if (ctl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign vars = v_reg;

endmodule

`default_nettype wire
